FILE: src/rdt_pkg.sv
package rdt_pkg;

  // Default number of table entries.
  localparam int unsigned TableDepth = 64;

  // Operation codes carried on the mode field.
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  // Status codes returned with every result.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;

  // One table entry as held in the memory.
  typedef struct packed {
    logic [15:0] bound;
    logic [15:0] delta;
  } entry_t;

  // One result passed from the controller to the output register.
  typedef struct packed {
    logic [15:0] delta;
    logic [1:0]  status;
  } res_t;

endpackage

FILE: src/rdt_ram.sv
module rdt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = rdt_pkg::TableDepth
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single write port and a registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/rdt_ctrl.sv
module rdt_ctrl #(
  parameter int unsigned TABLE_DEPTH = rdt_pkg::TableDepth,
  localparam int unsigned IdxW = $clog2(TABLE_DEPTH),
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            mode_i,
  input  logic [15:0]           offset_i,
  input  logic [15:0]           delta_in_i,
  input  logic                  out_free_i,
  output logic                  res_valid_o,
  output rdt_pkg::res_t         res_o,
  output logic                  ram_we_o,
  output logic [IdxW-1:0]       ram_waddr_o,
  output rdt_pkg::entry_t       ram_wdata_o,
  output logic                  ram_re_o,
  output logic [IdxW-1:0]       ram_raddr_o,
  input  rdt_pkg::entry_t       ram_rdata_i
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SRCH = 4'b0010,
    S_CMP  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [15:0]     last_bound_q, last_bound_d;
  logic [15:0]     key_q, key_d;
  logic [CntW-1:0] lo_q, lo_d;
  logic [CntW-1:0] hi_q, hi_d;
  logic [CntW-1:0] mid_q, mid_d;
  rdt_pkg::res_t   res_q, res_d;
  logic [CntW:0]   mid_sum;
  logic            accept;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};

  // Memory ports: appends write at the fill count, the search reads at the midpoint.
  assign ram_waddr_o       = count_q[IdxW-1:0];
  assign ram_wdata_o.bound = offset_i;
  assign ram_wdata_o.delta = delta_in_i;
  assign ram_raddr_o       = mid_sum[IdxW:1];

  assign res_valid_o = (state_q == S_DONE) && out_free_i;
  assign res_o       = res_q;

  // Sequencer. One transaction is in flight at a time, so a search never
  // overlaps a write and the memory needs no forwarding.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    last_bound_d = last_bound_q;
    key_d        = key_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    res_d        = res_q;
    ram_we_o     = 1'b0;
    ram_re_o     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d.delta  = '0;
          res_d.status = rdt_pkg::ST_OK;
          state_d      = S_DONE;
          case (mode_i)
            rdt_pkg::MODE_CLEAR: begin
              count_d = '0;
            end
            rdt_pkg::MODE_ADD: begin
              if (count_q == CntW'(TABLE_DEPTH)) begin
                res_d.status = rdt_pkg::ST_FULL;
              end else if ((count_q != '0) && (last_bound_q >= offset_i)) begin
                res_d.status = rdt_pkg::ST_ORDER;
              end else begin
                ram_we_o     = 1'b1;
                count_d      = count_q + CntW'(1);
                last_bound_d = offset_i;
              end
            end
            rdt_pkg::MODE_LOOKUP: begin
              key_d   = offset_i;
              lo_d    = '0;
              hi_d    = count_q;
              state_d = S_SRCH;
            end
            default: begin
            end
          endcase
        end
      end
      S_SRCH: begin
        // The interval [lo, hi) still holds candidates while it is not empty.
        if (lo_q == hi_q) begin
          state_d = S_DONE;
        end else begin
          ram_re_o = 1'b1;
          mid_d    = mid_sum[CntW:1];
          state_d  = S_CMP;
        end
      end
      S_CMP: begin
        // A bound at or below the key is the best match so far.
        if (ram_rdata_i.bound <= key_q) begin
          lo_d        = mid_q + CntW'(1);
          res_d.delta = ram_rdata_i.delta;
        end else begin
          hi_d = mid_q;
        end
        state_d = S_SRCH;
      end
      S_DONE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Search and result registers.
  always_ff @(posedge clk_i) begin
    last_bound_q <= last_bound_d;
    key_q        <= key_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    res_q        <= res_d;
  end

endmodule

FILE: src/range_delta_table_unit.sv
// Ordered offset remapping table. A clear empties the table, an add appends
// a (lower bound, delta) entry whose bound must be strictly above the last
// one, and a lookup returns the delta of the entry with the largest bound
// not above the offset, or zero. Every transaction gives exactly one result.
// Entries sit in a synchronous memory with one write and one read port. A
// lookup is a binary search: it is accepted in S_IDLE, each probe reads the
// memory in S_SRCH and compares in S_CMP, S_SRCH ends the search when it
// finds the interval empty, and S_DONE hands the result on. The input is
// held from acceptance until the result is handed on. Clear, add and unused
// modes go straight from S_IDLE to S_DONE. A result waits in an output
// register, and the next transaction is taken while it does; the hand-on
// state waits for as long as that register is held by a stalled result.
module range_delta_table_unit #(
  parameter int unsigned TABLE_DEPTH = rdt_pkg::TableDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [15:0]        offset_i,
  input  logic signed [15:0] delta_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] delta_out_o,
  output logic [1:0]         status_o
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);

  logic            out_valid_q, out_valid_d;
  rdt_pkg::res_t   out_res_q;
  logic            out_free;
  logic            res_valid;
  rdt_pkg::res_t   res;
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  rdt_pkg::entry_t ram_wdata;
  logic            ram_re;
  logic [IdxW-1:0] ram_raddr;
  rdt_pkg::entry_t ram_rdata;

  rdt_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .offset_i    (offset_i),
    .delta_in_i  (delta_in_i),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  rdt_ram #(
    .WIDTH($bits(rdt_pkg::entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output register: free when empty or when its transaction completes now.
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_d = res_valid || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign delta_out_o = out_res_q.delta;
  assign status_o    = out_res_q.status;

endmodule

FILE: src/rdt_checker.sv
module rdt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] delta_out_o,
  input logic [1:0]  status_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(delta_out_o) && $stable(status_o))
    else $error("result payload changed while stalled");

  // A rejected add never carries a delta.
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != rdt_pkg::ST_OK) |-> delta_out_o == 16'd0)
    else $error("flagged result with non-zero delta");

  // The block is busy in the cycle after it takes a transaction.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction taken while one is in flight");

endmodule

bind range_delta_table_unit rdt_checker u_rdt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .delta_out_o (delta_out_o),
  .status_o    (status_o)
);
